[rtl/mrc_pkg.sv]
package mrc_pkg;

  // Frame length limits in bytes
  localparam int MIN_FRAME = 8;
  localparam int MAX_FRAME = 256;
  // Byte counter saturates at MAX_FRAME + 1
  localparam int CNT_W = $clog2(MAX_FRAME + 2);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] QTY_MAX  = 16'h07D0;
  localparam logic [7:0]  EXC_FLAG = 8'h80;

  // Function codes
  localparam logic [7:0] FC_READ_COILS  = 8'd1;
  localparam logic [7:0] FC_READ_DI     = 8'd2;
  localparam logic [7:0] FC_READ_HR     = 8'd3;
  localparam logic [7:0] FC_READ_IR     = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
  localparam logic [7:0] FC_WRITE_REG   = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

  // Exception codes
  localparam logic [7:0] EXC_ILL_FUNC  = 8'd1;
  localparam logic [7:0] EXC_ILL_ADDR  = 8'd2;
  localparam logic [7:0] EXC_ILL_VALUE = 8'd3;

  // Configuration registers
  typedef struct packed {
    logic [7:0]  slave_address;
    logic [15:0] coil_count;
    logic [15:0] discrete_input_count;
    logic [15:0] holding_register_count;
  } cfg_t;

  // Verdict handed from frame receiver to response engine
  typedef struct packed {
    logic        is_disp;
    logic [7:0]  addr;
    logic [7:0]  func_code;
    logic [7:0]  exc_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
  } verdict_t;

  // One entry of the byte-wise CRC-16/Modbus table
  function automatic logic [15:0] crc_tbl(input logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Advance the CRC register by one byte
  function automatic logic [15:0] crc_upd(input logic [15:0] crc, input logic [7:0] b);
    return {8'h00, crc[15:8]} ^ crc_tbl(crc[7:0] ^ b);
  endfunction

endpackage

[rtl/mrc_front.sv]
module mrc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              frame_last_i,
  input  mrc_pkg::cfg_t     cfg_i,
  output logic              vq_push_o,
  output mrc_pkg::verdict_t vq_data_o
);

  logic [mrc_pkg::CNT_W-1:0] count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] hist0_q, hist0_d, hist1_q, hist1_d;
  logic [7:0]  rec0_q, rec0_d, rec1_q, rec1_d;
  logic [7:0]  hdr_q [6];
  logic [7:0]  hdr_d [6];
  logic        upd;
  logic        frame_ok;
  logic        has_res;
  logic        qty_chk, qty_bad;
  logic [15:0] start_w, qty_w, limit;
  logic [16:0] sum_w;
  logic [7:0]  fc;
  mrc_pkg::verdict_t vd;

  // Next frame state with the current byte folded in
  always_comb begin
    upd     = count_q <= mrc_pkg::CNT_W'(mrc_pkg::MAX_FRAME);
    count_d = upd ? count_q + 1'b1 : count_q;
    crc_d   = upd ? mrc_pkg::crc_upd(crc_q, rx_byte_i) : crc_q;
    hist0_d = upd ? hist1_q : hist0_q;
    hist1_d = upd ? crc_q : hist1_q;
    rec0_d  = upd ? rec1_q : rec0_q;
    rec1_d  = upd ? rx_byte_i : rec1_q;
    for (int i = 0; i < 6; i++) begin
      hdr_d[i] = (upd && count_q == mrc_pkg::CNT_W'(i)) ? rx_byte_i : hdr_q[i];
    end
  end

  // Frame-level checks on the completed frame
  always_comb begin
    fc       = hdr_d[1];
    start_w  = {hdr_d[2], hdr_d[3]};
    qty_w    = {hdr_d[4], hdr_d[5]};
    sum_w    = {1'b0, start_w} + {1'b0, qty_w};
    frame_ok = (count_d >= mrc_pkg::CNT_W'(mrc_pkg::MIN_FRAME))
            && (count_d <= mrc_pkg::CNT_W'(mrc_pkg::MAX_FRAME))
            && (hdr_d[0] == cfg_i.slave_address)
            && (rec0_d == hist0_d[7:0])
            && (rec1_d == hist0_d[15:8]);
  end

  // Classify the request
  always_comb begin
    vd.is_disp       = 1'b0;
    vd.addr          = hdr_d[0];
    vd.func_code     = fc;
    vd.exc_code      = mrc_pkg::EXC_ILL_FUNC;
    vd.start_address = start_w;
    vd.quantity      = qty_w;
    has_res          = 1'b0;
    qty_chk = fc inside {mrc_pkg::FC_READ_COILS, mrc_pkg::FC_READ_DI, mrc_pkg::FC_READ_HR,
                         mrc_pkg::FC_READ_IR, mrc_pkg::FC_WRITE_COILS,
                         mrc_pkg::FC_WRITE_REGS};
    qty_bad = (qty_w == 16'h0000) || (qty_w > mrc_pkg::QTY_MAX);
    case (fc)
      mrc_pkg::FC_READ_COILS: limit = cfg_i.coil_count;
      mrc_pkg::FC_READ_DI:    limit = cfg_i.discrete_input_count;
      default:                limit = cfg_i.holding_register_count;
    endcase
    if (qty_chk && qty_bad) begin
      vd.exc_code = mrc_pkg::EXC_ILL_VALUE;
      has_res     = 1'b1;
    end else begin
      case (fc)
        mrc_pkg::FC_READ_COILS, mrc_pkg::FC_READ_DI, mrc_pkg::FC_READ_HR: begin
          has_res = 1'b1;
          if (sum_w > {1'b0, limit}) begin
            vd.exc_code = mrc_pkg::EXC_ILL_ADDR;
          end else begin
            vd.is_disp = 1'b1;
          end
        end
        mrc_pkg::FC_WRITE_COIL: begin
          has_res = 1'b1;
          if (start_w >= cfg_i.coil_count) begin
            vd.exc_code = mrc_pkg::EXC_ILL_ADDR;
          end else begin
            vd.is_disp = 1'b1;
          end
        end
        mrc_pkg::FC_READ_IR, mrc_pkg::FC_WRITE_REG, mrc_pkg::FC_WRITE_COILS,
        mrc_pkg::FC_WRITE_REGS: begin
          has_res = 1'b0;
        end
        default: begin
          vd.exc_code = mrc_pkg::EXC_ILL_FUNC;
          has_res     = 1'b1;
        end
      endcase
    end
  end

  assign vq_push_o = accept_i && frame_last_i && frame_ok && has_res;
  assign vq_data_o = vd;

  // Advance frame state; clear it after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= mrc_pkg::CRC_INIT;
      hist0_q <= mrc_pkg::CRC_INIT;
      hist1_q <= mrc_pkg::CRC_INIT;
      rec0_q  <= '0;
      rec1_q  <= '0;
      for (int i = 0; i < 6; i++) hdr_q[i] <= '0;
    end else if (accept_i) begin
      if (frame_last_i) begin
        count_q <= '0;
        crc_q   <= mrc_pkg::CRC_INIT;
        hist0_q <= mrc_pkg::CRC_INIT;
        hist1_q <= mrc_pkg::CRC_INIT;
        rec0_q  <= '0;
        rec1_q  <= '0;
        for (int i = 0; i < 6; i++) hdr_q[i] <= '0;
      end else begin
        count_q <= count_d;
        crc_q   <= crc_d;
        hist0_q <= hist0_d;
        hist1_q <= hist1_d;
        rec0_q  <= rec0_d;
        rec1_q  <= rec1_d;
        for (int i = 0; i < 6; i++) hdr_q[i] <= hdr_d[i];
      end
    end
  end

endmodule

[rtl/mrc_vq.sv]
module mrc_vq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mrc_pkg::verdict_t data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output mrc_pkg::verdict_t data_o
);

  mrc_pkg::verdict_t mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  // Store verdicts
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

[rtl/mrc_back.sv]
module mrc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vq_valid_i,
  input  mrc_pkg::verdict_t vq_data_i,
  output logic              vq_pop_o,
  input  logic              pop_i,
  output logic              out_valid_o,
  output logic              kind_o,
  output logic [7:0]        tx_byte_o,
  output logic [7:0]        func_code_o,
  output logic [15:0]       start_address_o,
  output logic [15:0]       quantity_o,
  output logic              last_o
);

  typedef enum logic [4:0] {
    ST_ADDR = 5'b00001,
    ST_FUNC = 5'b00010,
    ST_CODE = 5'b00100,
    ST_CRCL = 5'b01000,
    ST_CRCH = 5'b10000
  } st_e;

  st_e         st_q, st_d;
  logic [15:0] crc_q, crc_d;
  logic        out_v_q;
  logic        kind_q, last_q;
  logic [7:0]  tx_q, fc_q;
  logic [15:0] sa_q, qt_q;
  logic        slot_free, emit;
  logic [7:0]  exc_byte;
  logic        exc_last;

  assign slot_free = !out_v_q || pop_i;
  assign emit      = vq_valid_i && slot_free;

  // Pick the exception byte and advance the CRC over the first three
  always_comb begin
    exc_last = 1'b0;
    st_d     = st_q;
    crc_d    = crc_q;
    case (st_q)
      ST_ADDR: begin
        exc_byte = vq_data_i.addr;
        crc_d    = mrc_pkg::crc_upd(mrc_pkg::CRC_INIT, exc_byte);
        st_d     = ST_FUNC;
      end
      ST_FUNC: begin
        exc_byte = vq_data_i.func_code + mrc_pkg::EXC_FLAG;
        crc_d    = mrc_pkg::crc_upd(crc_q, exc_byte);
        st_d     = ST_CODE;
      end
      ST_CODE: begin
        exc_byte = vq_data_i.exc_code;
        crc_d    = mrc_pkg::crc_upd(crc_q, exc_byte);
        st_d     = ST_CRCL;
      end
      ST_CRCL: begin
        exc_byte = crc_q[7:0];
        st_d     = ST_CRCH;
      end
      ST_CRCH: begin
        exc_byte = crc_q[15:8];
        exc_last = 1'b1;
        st_d     = ST_ADDR;
      end
      default: begin
        exc_byte = '0;
        st_d     = ST_ADDR;
      end
    endcase
  end

  assign vq_pop_o = emit && (vq_data_i.is_disp || exc_last);

  // Sequence the exception frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_ADDR;
      crc_q <= mrc_pkg::CRC_INIT;
    end else if (emit && !vq_data_i.is_disp) begin
      st_q  <= st_d;
      crc_q <= crc_d;
    end
  end

  // Hold the output valid until the transaction is popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (emit) begin
      out_v_q <= 1'b1;
    end else if (pop_i) begin
      out_v_q <= 1'b0;
    end
  end

  // Load the output payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (vq_data_i.is_disp) begin
        kind_q <= 1'b1;
        tx_q   <= '0;
        fc_q   <= vq_data_i.func_code;
        sa_q   <= vq_data_i.start_address;
        qt_q   <= vq_data_i.quantity;
        last_q <= 1'b1;
      end else begin
        kind_q <= 1'b0;
        tx_q   <= exc_byte;
        fc_q   <= '0;
        sa_q   <= '0;
        qt_q   <= '0;
        last_q <= exc_last;
      end
    end
  end

  assign out_valid_o     = out_v_q;
  assign kind_o          = kind_q;
  assign tx_byte_o       = tx_q;
  assign func_code_o     = fc_q;
  assign start_address_o = sa_q;
  assign quantity_o      = qt_q;
  assign last_o          = last_q;

endmodule

[rtl/modbus_rtu_request_checker.sv]
// Modbus RTU request checker.
// Input queue port: one received frame byte per transaction (push/full), with
// frame_last_i on the final byte. Bytes are taken one per cycle while full is
// low; full rises only when the two-entry verdict queue between frame receiver
// and response engine is full.
// Result queue port (empty/pop): a rejected request yields nothing, an
// exception yields five byte results (address, code + 0x80, exception code,
// CRC low, CRC high), an accepted request of function 1, 2, 3 or 5 yields one
// dispatch result, others none. last_o marks the final result of a frame.
// A frame's verdict passes the verdict queue and the output register. Results
// leave at one per cycle while pop is held, set by the response engine, which
// works one exception byte per cycle, with a CRC table step on the first three.
// A stalled receiver holds the output register; the response engine and then
// the verdict queue back up, and only then is input refused.
// Configuration (APB, always ready): slave address at 0x0, coil count at 0x4,
// discrete input count at 0x8, holding register count at 0xC; write only
// while idle. Reset clears frame state and loads address 1 and counts of 0.
module modbus_rtu_request_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_last_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [7:0]  func_code_o,
  output logic [15:0] start_address_o,
  output logic [15:0] quantity_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] REG_COIL_CNT   = 2'd1;
  localparam logic [1:0] REG_DI_CNT     = 2'd2;
  localparam logic [1:0] REG_HR_CNT     = 2'd3;

  mrc_pkg::cfg_t     cfg_q;
  mrc_pkg::verdict_t vq_in, vq_out;
  logic              vq_push, vq_pop, vq_full, vq_valid;
  logic              rx_accept;
  logic              out_valid;
  logic              cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address          <= 8'd1;
      cfg_q.coil_count             <= '0;
      cfg_q.discrete_input_count   <= '0;
      cfg_q.holding_register_count <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SLAVE_ADDR: cfg_q.slave_address          <= pwdata[7:0];
        REG_COIL_CNT:   cfg_q.coil_count             <= pwdata[15:0];
        REG_DI_CNT:     cfg_q.discrete_input_count   <= pwdata[15:0];
        REG_HR_CNT:     cfg_q.holding_register_count <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SLAVE_ADDR: prdata = {24'h0, cfg_q.slave_address};
      REG_COIL_CNT:   prdata = {16'h0, cfg_q.coil_count};
      REG_DI_CNT:     prdata = {16'h0, cfg_q.discrete_input_count};
      REG_HR_CNT:     prdata = {16'h0, cfg_q.holding_register_count};
      default:        prdata = '0;
    endcase
  end

  // Input handshake
  assign full      = vq_full;
  assign rx_accept = push && !full;

  mrc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (rx_accept),
    .rx_byte_i    (rx_byte_i),
    .frame_last_i (frame_last_i),
    .cfg_i        (cfg_q),
    .vq_push_o    (vq_push),
    .vq_data_o    (vq_in)
  );

  mrc_vq u_vq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (vq_push),
    .data_i  (vq_in),
    .pop_i   (vq_pop),
    .full_o  (vq_full),
    .valid_o (vq_valid),
    .data_o  (vq_out)
  );

  mrc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vq_valid_i      (vq_valid),
    .vq_data_i       (vq_out),
    .vq_pop_o        (vq_pop),
    .pop_i           (pop),
    .out_valid_o     (out_valid),
    .kind_o          (kind_o),
    .tx_byte_o       (tx_byte_o),
    .func_code_o     (func_code_o),
    .start_address_o (start_address_o),
    .quantity_o      (quantity_o),
    .last_o          (last_o)
  );

  assign empty = !out_valid;

`ifndef SYNTHESIS
  a_vq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vq_full |-> !vq_push) else $error("verdict queue overflow");

  a_vq_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vq_pop |-> vq_valid) else $error("verdict queue underflow");

  a_disp_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o) |-> last_o) else $error("dispatch result without last");

  a_exc_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !kind_o && !last_o) |=> (!empty && !kind_o))
    else $error("exception frame broken off");
`endif

endmodule
